@@ sv/utlm_pkg.sv @@
`timescale 1ns / 1ps
package utlm_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_TO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_TO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA    = 3'd4;

  // Register values after reset.
  localparam logic [7:0]  RST_TRIGGER = 8'd10;
  localparam logic [15:0] RST_RISE_TO = 16'd10000;
  localparam logic [15:0] RST_FALL_TO = 16'd50000;
  localparam logic [15:0] RST_HEIGHT  = 16'd284;
  localparam logic [15:0] RST_AREA    = 16'd11310;

  // Echo width as carried to the arithmetic side, wide enough for counters of up to 32 bits.
  localparam int unsigned WIDTH_W = 32;

  // Distance: floor(width * 343 / 20000), saturated at 1023.
  localparam logic [40:0] DIST_MUL     = 41'd343;
  localparam logic [40:0] DIST_SAT_LIM = 41'd20480000;
  localparam logic [9:0]  DIST_MAX     = 10'd1023;
  // Division by 20000 is a shift by 5 and a multiply by ceil(2^30 / 625),
  // exact for the 20-bit operand left after the shift.
  localparam logic [20:0] DIST_RECIP   = 21'd1717987;

  // Volume: floor(area * rem / 256 / 10), saturated at 65535.
  localparam logic [31:0] VOL_SAT_LIM = 32'd167772160;
  localparam logic [15:0] VOL_MAX     = 16'hFFFF;
  localparam logic [13:0] TENTHS      = 14'd10;
  // Division by 10 is a multiply by ceil(2^24 / 10), exact for 20-bit operands.
  localparam logic [20:0] VOL_RECIP   = 21'd1677722;

  // Depth of the queue between the sequencer and the arithmetic side.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_ECHO
  } phase_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL_D,
    B_DIV_D,
    B_REM,
    B_MUL_V,
    B_DIV_V,
    B_OUT
  } bstate_t;

  typedef struct packed {
    logic cmd;
    logic echo;
  } in_item_t;

  typedef struct packed {
    logic        trigger_out;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [9:0]  distance_cm;
    logic [15:0] volume_ml;
  } out_item_t;

  // One classified item on its way to the arithmetic side.
  typedef struct packed {
    logic               trigger_out;
    logic               busy_res;
    logic               done_res;
    logic               timed_out;
    logic [WIDTH_W-1:0] width;
  } job_t;

endpackage

@@ sv/utlm_front.sv @@
`timescale 1ns / 1ps
module utlm_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  utlm_pkg::in_item_t  in_item,
  input  logic [7:0]          cfg_trigger,
  input  logic [15:0]         cfg_rise_to,
  input  logic [15:0]         cfg_fall_to,
  output utlm_pkg::job_t      job
);

  localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  utlm_pkg::phase_t         ph_r, ph_nxt;
  logic [COUNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic                     flag_r, flag_nxt;
  logic [COUNT_WIDTH-1:0]   cnt_inc;
  logic [LW-1:0]            cnt_inc_w;
  logic                     at_max;
  logic                     hit_trig, hit_rise, hit_fall;
  logic                     done;
  logic [COUNT_WIDTH-1:0]   width;

  // Saturating tick counter and limit checks; a zero limit ends after one tick.
  assign cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + COUNT_WIDTH'(1);
  assign cnt_inc_w = LW'(cnt_inc);
  assign at_max    = (cnt_inc == CNT_MAX);
  assign hit_trig  = (cnt_inc_w >= LW'(cfg_trigger)) || at_max;
  assign hit_rise  = (cnt_inc_w >= LW'(cfg_rise_to)) || at_max;
  assign hit_fall  = (cnt_inc_w >= LW'(cfg_fall_to)) || at_max;

  // Phase and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= utlm_pkg::PH_IDLE;
      cnt_r  <= '0;
      flag_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
      flag_r <= flag_nxt;
    end
  end

  // Measurement sequencing, one step per accepted item.
  always_comb begin
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    flag_nxt = flag_r;
    done     = 1'b0;
    width    = '0;
    if (accept) begin
      if (in_item.cmd) begin
        ph_nxt  = utlm_pkg::PH_TRIG;
        cnt_nxt = '0;
      end else begin
        unique case (ph_r)
          utlm_pkg::PH_TRIG: begin
            if (hit_trig) begin
              ph_nxt  = utlm_pkg::PH_RISE;
              cnt_nxt = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          utlm_pkg::PH_RISE: begin
            if (in_item.echo) begin
              ph_nxt  = utlm_pkg::PH_ECHO;
              cnt_nxt = '0;
            end else if (hit_rise) begin
              ph_nxt   = utlm_pkg::PH_IDLE;
              cnt_nxt  = '0;
              flag_nxt = 1'b1;
              done     = 1'b1;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          utlm_pkg::PH_ECHO: begin
            if (!in_item.echo) begin
              ph_nxt   = utlm_pkg::PH_IDLE;
              cnt_nxt  = '0;
              flag_nxt = 1'b0;
              done     = 1'b1;
              width    = cnt_r;
            end else if (hit_fall) begin
              ph_nxt   = utlm_pkg::PH_IDLE;
              cnt_nxt  = '0;
              flag_nxt = 1'b1;
              done     = 1'b1;
              width    = cnt_inc;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          default: begin
            ph_nxt = ph_r;
          end
        endcase
      end
    end
  end

  // Classified item for the queue.
  assign job.trigger_out = (ph_nxt == utlm_pkg::PH_TRIG);
  assign job.busy_res    = (ph_nxt != utlm_pkg::PH_IDLE);
  assign job.done_res    = done;
  assign job.timed_out   = flag_nxt;
  assign job.width       = utlm_pkg::WIDTH_W'(width);

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && job.done_res |-> !job.busy_res)
    else $error("completed measurement still marked busy");

  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && job.trigger_out |-> job.busy_res)
    else $error("trigger driven while not busy");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == utlm_pkg::PH_IDLE |-> cnt_r == '0)
    else $error("tick counter not cleared while idle");

endmodule

@@ sv/utlm_fifo.sv @@
`timescale 1ns / 1ps
module utlm_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

@@ sv/utlm_back.sv @@
`timescale 1ns / 1ps
module utlm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           cfg_height,
  input  logic [15:0]           cfg_area,
  input  utlm_pkg::job_t        q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output utlm_pkg::out_item_t   out_item,
  output logic                  out_empty,
  input  logic                  out_pop
);

  utlm_pkg::bstate_t    bst_r, bst_nxt;
  utlm_pkg::job_t       job_r, job_nxt;
  logic [9:0]           dist_r, dist_nxt;
  logic [15:0]          vol_r, vol_nxt;
  logic [15:0]          diff_r, diff_nxt;
  logic                 vpos_r, vpos_nxt;
  logic [19:0]          scaled_r, scaled_nxt;
  utlm_pkg::out_item_t  out_r, out_nxt;
  logic                 out_vld_r, out_vld_nxt;

  logic                 slot_free;
  logic                 wr_out;
  logic [40:0]          prod_d;
  logic [13:0]          dist10;
  logic [31:0]          prod_v;
  logic [40:0]          recip_d;
  logic [40:0]          recip_v;

  assign slot_free = !out_vld_r || out_pop;
  assign out_item  = out_r;
  assign out_empty = !out_vld_r;

  // Products for distance and volume.
  assign prod_d = 41'(job_r.width) * utlm_pkg::DIST_MUL;
  assign dist10 = 14'(dist_r) * utlm_pkg::TENTHS;
  assign prod_v = 32'(cfg_area) * 32'(diff_r);

  // Reciprocal multiplications that stand in for the constant divisions.
  assign recip_d = 41'(scaled_r) * 41'(utlm_pkg::DIST_RECIP);
  assign recip_v = 41'(scaled_r) * 41'(utlm_pkg::VOL_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r     <= utlm_pkg::B_IDLE;
      out_vld_r <= 1'b0;
      dist_r    <= '0;
      vol_r     <= '0;
    end else begin
      bst_r     <= bst_nxt;
      out_vld_r <= out_vld_nxt;
      dist_r    <= dist_nxt;
      vol_r     <= vol_nxt;
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    diff_r   <= diff_nxt;
    vpos_r   <= vpos_nxt;
    scaled_r <= scaled_nxt;
    out_r    <= out_nxt;
  end

  // Sequencer for the arithmetic and the result register.
  always_comb begin
    bst_nxt    = bst_r;
    job_nxt    = job_r;
    dist_nxt   = dist_r;
    vol_nxt    = vol_r;
    diff_nxt   = diff_r;
    vpos_nxt   = vpos_r;
    scaled_nxt = scaled_r;
    out_nxt    = out_r;
    q_pop      = 1'b0;
    wr_out     = 1'b0;
    unique case (bst_r)
      utlm_pkg::B_IDLE: begin
        if (!q_empty) begin
          if (q_head.done_res) begin
            q_pop   = 1'b1;
            job_nxt = q_head;
            bst_nxt = utlm_pkg::B_MUL_D;
          end else if (slot_free) begin
            q_pop   = 1'b1;
            wr_out  = 1'b1;
            out_nxt = '{trigger_out: q_head.trigger_out, busy_res: q_head.busy_res,
                        done_res: q_head.done_res, timed_out: q_head.timed_out,
                        distance_cm: dist_r, volume_ml: vol_r};
          end
        end
      end
      utlm_pkg::B_MUL_D: begin
        if (prod_d >= utlm_pkg::DIST_SAT_LIM) begin
          dist_nxt = utlm_pkg::DIST_MAX;
          bst_nxt  = utlm_pkg::B_REM;
        end else begin
          // The product is below 2^25 here; dropping five bits divides by 32.
          scaled_nxt = prod_d[24:5];
          bst_nxt    = utlm_pkg::B_DIV_D;
        end
      end
      utlm_pkg::B_DIV_D: begin
        dist_nxt = recip_d[39:30];
        bst_nxt  = utlm_pkg::B_REM;
      end
      utlm_pkg::B_REM: begin
        vpos_nxt = (cfg_height > 16'(dist10));
        diff_nxt = cfg_height - 16'(dist10);
        bst_nxt  = utlm_pkg::B_MUL_V;
      end
      utlm_pkg::B_MUL_V: begin
        if (!vpos_r) begin
          vol_nxt = '0;
          bst_nxt = utlm_pkg::B_OUT;
        end else if (prod_v >= utlm_pkg::VOL_SAT_LIM) begin
          vol_nxt = utlm_pkg::VOL_MAX;
          bst_nxt = utlm_pkg::B_OUT;
        end else begin
          // The product is below 2^28 here; dropping eight bits divides by 256.
          scaled_nxt = prod_v[27:8];
          bst_nxt    = utlm_pkg::B_DIV_V;
        end
      end
      utlm_pkg::B_DIV_V: begin
        vol_nxt = recip_v[39:24];
        bst_nxt = utlm_pkg::B_OUT;
      end
      utlm_pkg::B_OUT: begin
        if (slot_free) begin
          wr_out  = 1'b1;
          out_nxt = '{trigger_out: job_r.trigger_out, busy_res: job_r.busy_res,
                      done_res: job_r.done_res, timed_out: job_r.timed_out,
                      distance_cm: dist_r, volume_ml: vol_r};
          bst_nxt = utlm_pkg::B_IDLE;
        end
      end
      default: begin
        bst_nxt = utlm_pkg::B_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (wr_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  a_busy_job_done: assert property (@(posedge clk) disable iff (!rst_n)
    bst_r != utlm_pkg::B_IDLE |-> job_r.done_res)
    else $error("arithmetic running for an item that ends no measurement");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bst_r != utlm_pkg::B_IDLE |-> !q_pop)
    else $error("queue read while arithmetic is running");

endmodule

@@ sv/ultrasonic_tank_level_meter.sv @@
`timescale 1ns / 1ps
// Path: an item that does not end a measurement goes through the queue and then
// the result register once it is free; one that ends a measurement also steps
// through the arithmetic states, fewer when a result saturates or the remaining
// height is not positive. Throughput: one item per cycle while the four-item
// queue has room; a finished measurement holds the arithmetic side, so it fills.
// Reset: synchronous, active low; phase idle, counters and results zero,
// configuration registers back to their defaults.
module ultrasonic_tank_level_meter #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  utlm_pkg::in_item_t                   in_item,
  output logic                                 empty,
  input  logic                                 pop,
  output utlm_pkg::out_item_t                  out_item,
  input  logic                                 cfg_wr_en,
  input  logic [utlm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [utlm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int JW = $bits(utlm_pkg::job_t);

  logic [7:0]     trig_r;
  logic [15:0]    rise_to_r;
  logic [15:0]    fall_to_r;
  logic [15:0]    height_r;
  logic [15:0]    area_r;
  logic           accept;
  utlm_pkg::job_t job_in;
  logic [JW-1:0]  q_data;
  logic           q_empty;
  logic           q_pop;

  assign accept = push && !full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r    <= utlm_pkg::RST_TRIGGER;
      rise_to_r <= utlm_pkg::RST_RISE_TO;
      fall_to_r <= utlm_pkg::RST_FALL_TO;
      height_r  <= utlm_pkg::RST_HEIGHT;
      area_r    <= utlm_pkg::RST_AREA;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        utlm_pkg::REG_TRIGGER: trig_r    <= cfg_data[7:0];
        utlm_pkg::REG_RISE_TO: rise_to_r <= cfg_data;
        utlm_pkg::REG_FALL_TO: fall_to_r <= cfg_data;
        utlm_pkg::REG_HEIGHT:  height_r  <= cfg_data;
        utlm_pkg::REG_AREA:    area_r    <= cfg_data;
        default: begin
          trig_r <= trig_r;
        end
      endcase
    end
  end

  utlm_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_item     (in_item),
    .cfg_trigger (trig_r),
    .cfg_rise_to (rise_to_r),
    .cfg_fall_to (fall_to_r),
    .job         (job_in)
  );

  utlm_fifo #(
    .DEPTH (utlm_pkg::QUEUE_DEPTH),
    .WIDTH (JW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (job_in),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  utlm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_height (height_r),
    .cfg_area   (area_r),
    .q_head     (utlm_pkg::job_t'(q_data)),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_item   (out_item),
    .out_empty  (empty),
    .out_pop    (pop)
  );

endmodule

@@ tb/sv/tb_ultrasonic_tank_level_meter.sv @@
`timescale 1ns / 1ps
module tb_ultrasonic_tank_level_meter;

  localparam int CNT_W = 16;
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum int {ROW_ITEM, ROW_TYPED, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    utlm_pkg::in_item_t item;
    utlm_pkg::out_item_t want;
    logic [utlm_pkg::CFG_IDX_W-1:0] idx;
    logic [utlm_pkg::CFG_DATA_W-1:0] data;
  } step_row_t;

  typedef struct {
    logic [7:0] trig;
    logic [15:0] rise;
    logic [15:0] fall;
    logic [15:0] height;
    logic [15:0] area;
    int budget;
  } tank_setup_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  utlm_pkg::in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  utlm_pkg::out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [utlm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [utlm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies seen by the level predictor.
  logic [7:0] reg_trig = utlm_pkg::RST_TRIGGER;
  logic [15:0] reg_rise = utlm_pkg::RST_RISE_TO;
  logic [15:0] reg_fall = utlm_pkg::RST_FALL_TO;
  logic [15:0] reg_height = utlm_pkg::RST_HEIGHT;
  logic [15:0] reg_area = utlm_pkg::RST_AREA;

  // Measurement state of the level predictor.
  utlm_pkg::phase_t gauge_phase = utlm_pkg::PH_IDLE;
  logic [CNT_W-1:0] gauge_ticks = '0;
  logic [9:0] gauge_dist = '0;
  logic [15:0] gauge_vol = '0;
  logic gauge_tout = 1'b0;

  utlm_pkg::out_item_t pending_readings[$];
  int fault_count = 0;
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int items_sent = 0;

  ultrasonic_tank_level_meter dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_item(in_item),
    .empty(empty),
    .pop(pop),
    .out_item(out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Count one tick, saturating; true once the limit or the counter top is reached.
  function automatic logic bump_ticks(logic [15:0] limit);
    if (gauge_ticks != '1) gauge_ticks = gauge_ticks + 1'b1;
    return (gauge_ticks >= limit) || (gauge_ticks == '1);
  endfunction

  // Turn an echo width into distance and remaining volume, then go idle.
  function automatic void settle_level(longint width, logic hit);
    longint range_cm;
    longint rem;
    longint vol;
    longint height;
    longint area;
    height = reg_height;
    area = reg_area;
    range_cm = (width * 343) / 20000;
    if (range_cm > 1023) range_cm = 1023;
    rem = height - range_cm * 10;
    if (rem <= 0) begin
      vol = 0;
    end else begin
      vol = (area * rem) / 2560;
      if (vol > 65535) vol = 65535;
    end
    gauge_dist = range_cm[9:0];
    gauge_vol = vol[15:0];
    gauge_tout = hit;
    gauge_phase = utlm_pkg::PH_IDLE;
    gauge_ticks = '0;
  endfunction

  // Reading the block should give for one accepted item.
  function automatic utlm_pkg::out_item_t predict_reading(utlm_pkg::in_item_t it);
    utlm_pkg::out_item_t r;
    logic done;
    done = 1'b0;
    if (it.cmd == CMD_START) begin
      gauge_phase = utlm_pkg::PH_TRIG;
      gauge_ticks = '0;
    end else begin
      case (gauge_phase)
        utlm_pkg::PH_TRIG: begin
          if (bump_ticks({8'd0, reg_trig})) begin
            gauge_phase = utlm_pkg::PH_RISE;
            gauge_ticks = '0;
          end
        end
        utlm_pkg::PH_RISE: begin
          if (it.echo) begin
            gauge_phase = utlm_pkg::PH_ECHO;
            gauge_ticks = '0;
          end else if (bump_ticks(reg_rise)) begin
            settle_level(0, 1'b1);
            done = 1'b1;
          end
        end
        utlm_pkg::PH_ECHO: begin
          if (!it.echo) begin
            settle_level(gauge_ticks, 1'b0);
            done = 1'b1;
          end else if (bump_ticks(reg_fall)) begin
            settle_level(gauge_ticks, 1'b1);
            done = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.trigger_out = (gauge_phase == utlm_pkg::PH_TRIG);
    r.busy_res = (gauge_phase != utlm_pkg::PH_IDLE);
    r.done_res = done;
    r.timed_out = gauge_tout;
    r.distance_cm = gauge_dist;
    r.volume_ml = gauge_vol;
    return r;
  endfunction

  function automatic step_row_t item_row(logic cmd, logic echo);
    step_row_t r;
    r = '{ROW_ITEM, utlm_pkg::in_item_t'{cmd, echo}, '0, '0, '0};
    return r;
  endfunction

  function automatic step_row_t typed_row(logic cmd, logic echo,
                                          utlm_pkg::out_item_t want);
    step_row_t r;
    r = '{ROW_TYPED, utlm_pkg::in_item_t'{cmd, echo}, want, '0, '0};
    return r;
  endfunction

  function automatic step_row_t write_row(logic [utlm_pkg::CFG_IDX_W-1:0] idx,
                                          logic [utlm_pkg::CFG_DATA_W-1:0] data);
    step_row_t r;
    r = '{ROW_WRITE, '0, '0, idx, data};
    return r;
  endfunction

  // Offer one item, wait for it to be taken and queue its expected reading.
  task automatic send_item(utlm_pkg::in_item_t it, bit typed = 1'b0,
                           utlm_pkg::out_item_t want = '0);
    utlm_pkg::out_item_t guess;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    guess = predict_reading(it);
    pending_readings.push_back(typed ? want : guess);
    items_sent++;
  endtask

  task automatic drain_readings();
    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Registers change only once every reading is out.
  task automatic write_reg(logic [utlm_pkg::CFG_IDX_W-1:0] idx,
                           logic [utlm_pkg::CFG_DATA_W-1:0] data);
    drain_readings();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      utlm_pkg::REG_TRIGGER: reg_trig = data[7:0];
      utlm_pkg::REG_RISE_TO: reg_rise = data;
      utlm_pkg::REG_FALL_TO: reg_fall = data;
      utlm_pkg::REG_HEIGHT: reg_height = data;
      utlm_pkg::REG_AREA: reg_area = data;
      default: ;
    endcase
  endtask

  task automatic program_tank(tank_setup_t s);
    write_reg(utlm_pkg::REG_TRIGGER, {8'd0, s.trig});
    write_reg(utlm_pkg::REG_RISE_TO, s.rise);
    write_reg(utlm_pkg::REG_FALL_TO, s.fall);
    write_reg(utlm_pkg::REG_HEIGHT, s.height);
    write_reg(utlm_pkg::REG_AREA, s.area);
  endtask

  // A well-formed measurement with random timing, sometimes cut short,
  // and never longer than room items.
  task automatic send_measurement(int room);
    utlm_pkg::in_item_t burst[$];
    int trig_len;
    int rise_lim;
    int wait_len;
    int width;
    int cut;
    trig_len = (reg_trig == 0) ? 1 : reg_trig;
    rise_lim = (reg_rise == 0) ? 1 : reg_rise;
    wait_len = $urandom_range(0, (rise_lim < 40) ? rise_lim + 2 : 40);
    case ($urandom_range(0, 7))
      0: width = 0;
      1: width = $urandom_range(400, 3000);
      default: width = $urandom_range(1, 400);
    endcase
    burst.push_back(utlm_pkg::in_item_t'{CMD_START, 1'($urandom_range(0, 1))});
    repeat (trig_len)
      burst.push_back(utlm_pkg::in_item_t'{CMD_TICK, 1'($urandom_range(0, 1))});
    repeat (wait_len) burst.push_back(utlm_pkg::in_item_t'{CMD_TICK, 1'b0});
    repeat (width + 1) burst.push_back(utlm_pkg::in_item_t'{CMD_TICK, 1'b1});
    burst.push_back(utlm_pkg::in_item_t'{CMD_TICK, 1'b0});
    repeat ($urandom_range(0, 3))
      burst.push_back(utlm_pkg::in_item_t'{CMD_TICK, 1'($urandom_range(0, 1))});
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, burst.size());
      while (burst.size() > cut) void'(burst.pop_back());
    end
    while (burst.size() > room) void'(burst.pop_back());
    foreach (burst[k]) send_item(burst[k]);
  endtask

  // A few loose items: stray ticks and the odd start.
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_item(utlm_pkg::in_item_t'{($urandom_range(0, 9) == 0) ? CMD_START : CMD_TICK,
                                     1'($urandom_range(0, 1))});
    end
  endtask

  // Take readings at random and compare each with the oldest expectation.
  always @(posedge clk) begin
    utlm_pkg::out_item_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_readings.size() == 0) begin
          $error("reading with none expected: %p", out_item);
          fault_count++;
        end else begin
          want = pending_readings.pop_front();
          if (out_item.trigger_out !== want.trigger_out) begin
            $error("trigger_out: expected %0d, got %0d", want.trigger_out,
                   out_item.trigger_out);
            fault_count++;
          end
          if (out_item.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, out_item.busy_res);
            fault_count++;
          end
          if (out_item.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, out_item.done_res);
            fault_count++;
          end
          if (out_item.timed_out !== want.timed_out) begin
            $error("timed_out: expected %0d, got %0d", want.timed_out, out_item.timed_out);
            fault_count++;
          end
          if (out_item.distance_cm !== want.distance_cm) begin
            $error("distance_cm: expected %0d, got %0d", want.distance_cm,
                   out_item.distance_cm);
            fault_count++;
          end
          if (out_item.volume_ml !== want.volume_ml) begin
            $error("volume_ml: expected %0d, got %0d", want.volume_ml, out_item.volume_ml);
            fault_count++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    step_row_t directed_rows[$];
    tank_setup_t plan[6];
    utlm_pkg::out_item_t cleared;
    utlm_pkg::out_item_t timeout_empty;

    cleared = '0;
    timeout_empty = utlm_pkg::out_item_t'{1'b0, 1'b0, 1'b1, 1'b1, 10'd0, 16'd0};

    // Short walk: defaults first, then zero limits, restart while busy, timeouts.
    directed_rows = '{
      typed_row(CMD_TICK, 1'b0, cleared),
      typed_row(CMD_TICK, 1'b1, cleared),
      typed_row(CMD_START, 1'b0,
                utlm_pkg::out_item_t'{1'b1, 1'b1, 1'b0, 1'b0, 10'd0, 16'd0}),
      item_row(CMD_TICK, 1'b1), item_row(CMD_TICK, 1'b0),
      item_row(CMD_TICK, 1'b1), item_row(CMD_TICK, 1'b0),
      item_row(CMD_TICK, 1'b0), item_row(CMD_TICK, 1'b1),
      item_row(CMD_TICK, 1'b0), item_row(CMD_TICK, 1'b0),
      item_row(CMD_TICK, 1'b1), item_row(CMD_TICK, 1'b0),
      item_row(CMD_TICK, 1'b1), item_row(CMD_TICK, 1'b1),
      item_row(CMD_TICK, 1'b0),
      write_row(utlm_pkg::REG_TRIGGER, 16'd0), write_row(utlm_pkg::REG_RISE_TO, 16'd0),
      write_row(utlm_pkg::REG_FALL_TO, 16'd0), write_row(utlm_pkg::REG_HEIGHT, 16'd0),
      write_row(utlm_pkg::REG_AREA, 16'hFFFF),
      item_row(CMD_START, 1'b0),
      item_row(CMD_TICK, 1'b1),
      typed_row(CMD_TICK, 1'b0, timeout_empty),
      item_row(CMD_START, 1'b0),
      item_row(CMD_TICK, 1'b0),
      typed_row(CMD_START, 1'b1,
                utlm_pkg::out_item_t'{1'b1, 1'b1, 1'b0, 1'b1, 10'd0, 16'd0}),
      item_row(CMD_TICK, 1'b0),
      item_row(CMD_TICK, 1'b1),
      typed_row(CMD_TICK, 1'b1, timeout_empty),
      typed_row(CMD_TICK, 1'b0,
                utlm_pkg::out_item_t'{1'b0, 1'b0, 1'b0, 1'b1, 10'd0, 16'd0})
    };

    // Register settings for the random part, with their item budgets.
    plan = '{
      '{8'd1, 16'd40, 16'd300, 16'd50, 16'd11310, 300},
      '{8'd255, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 550},
      '{8'd3, 16'd200, 16'd5000, 16'd1200, 16'd2560, 300},
      '{8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 200},
      '{8'd7, 16'hFFFF, 16'd800, 16'd4000, 16'd40000, 300},
      '{utlm_pkg::RST_TRIGGER, utlm_pkg::RST_RISE_TO, utlm_pkg::RST_FALL_TO,
        utlm_pkg::RST_HEIGHT, utlm_pkg::RST_AREA, 300}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      case (directed_rows[k].kind)
        ROW_WRITE: write_reg(directed_rows[k].idx, directed_rows[k].data);
        ROW_TYPED: send_item(directed_rows[k].item, 1'b1, directed_rows[k].want);
        default: send_item(directed_rows[k].item);
      endcase
    end

    // Random part: two settings per idling pattern.
    foreach (plan[s]) begin
      case (s / 2)
        0: begin
          send_idle_pct = 7;
          take_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          take_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      program_tank(plan[s]);
      items_sent = 0;
      while (items_sent < plan[s].budget) begin
        if ($urandom_range(0, 9) < 8) send_measurement(plan[s].budget - items_sent);
        else send_noise();
      end
    end

    // Let every reading out, then watch a while for strays.
    drain_readings();
    repeat (60) @(posedge clk);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/utlm_pkg.sv
sv/utlm_front.sv
sv/utlm_fifo.sv
sv/utlm_back.sv
sv/ultrasonic_tank_level_meter.sv
tb/sv/tb_ultrasonic_tank_level_meter.sv
